// ===== design/dpw_pkg.sv =====
// ----------------------------------------------------------------------------
// dpw_pkg
// Shared types, constants and helper functions for the depth pixel to world
// point pipeline.
// ----------------------------------------------------------------------------
package dpw_pkg;

  // Sampling grid and depth window.
  localparam int SAMPLE_STEP = 3;
  localparam logic [15:0] DEPTH_MIN_KEEP = 16'd41;
  localparam logic [15:0] DEPTH_MAX_KEEP = 16'd40960;

  // Quotient bits of the back-projection divide, one bit per stage.
  localparam int QBITS = 32;

  // Remainder test by reciprocal multiply, exact for 11 bit values.
  localparam int MOD_SHIFT = 16;
  localparam logic [17:0] MOD_MULT = 18'((1 << MOD_SHIFT) / SAMPLE_STEP + 1);
  localparam logic [3:0] STEP_W = 4'(SAMPLE_STEP);

  // Output saturation bounds.
  localparam logic signed [36:0] OUT_MAX = 37'sd8388607;
  localparam logic signed [36:0] OUT_MIN = -37'sd8388608;

  // Register reset values.
  localparam logic [15:0] FOCAL_X_RST = 16'd8000;
  localparam logic [15:0] FOCAL_Y_RST = 16'd8000;
  localparam logic [15:0] CENTER_X_RST = 16'd5120;
  localparam logic [15:0] CENTER_Y_RST = 16'd3840;
  localparam logic [63:0] POSE_X_RST = 64'd16384;
  localparam logic [63:0] POSE_Y_RST = 64'd1073741824;
  localparam logic [63:0] POSE_Z_RST = 64'd70368744177664;

  typedef enum logic [2:0] {
    REG_FOCAL_X  = 3'd0,
    REG_FOCAL_Y  = 3'd1,
    REG_CENTER_X = 3'd2,
    REG_CENTER_Y = 3'd3,
    REG_POSE_X   = 3'd4,
    REG_POSE_Y   = 3'd5,
    REG_POSE_Z   = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] focal_x;
    logic [15:0] focal_y;
    logic [15:0] center_x;
    logic [15:0] center_y;
    logic [63:0] pose_x;
    logic [63:0] pose_y;
    logic [63:0] pose_z;
  } cfg_t;

  // Dividend magnitudes and divisors headed into the divide pipeline.
  typedef struct packed {
    logic        valid;
    logic [31:0] mag_x;
    logic [31:0] mag_y;
    logic        neg_x;
    logic        neg_y;
    logic [15:0] den_x;
    logic [15:0] den_y;
    logic [15:0] depth;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
  } prod_t;

  // One stage of the divide pipeline.
  typedef struct packed {
    logic        valid;
    logic [15:0] rem_x;
    logic [15:0] rem_y;
    logic [31:0] dvd_x;
    logic [31:0] dvd_y;
    logic [31:0] q_x;
    logic [31:0] q_y;
    logic        neg_x;
    logic        neg_y;
    logic [15:0] den_x;
    logic [15:0] den_y;
    logic [15:0] depth;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
  } dst_t;

  // Camera frame point.
  typedef struct packed {
    logic               valid;
    logic signed [32:0] x;
    logic signed [32:0] y;
    logic [15:0]        depth;
    logic [7:0]         blue;
    logic [7:0]         green;
    logic [7:0]         red;
  } cam_t;

  // True when v is a multiple of the sample step.
  function automatic logic on_grid(input logic [10:0] v);
    logic [28:0] p;
    logic [10:0] q;
    logic [14:0] back;
    p = 29'(v) * 29'(MOD_MULT);
    q = p[MOD_SHIFT +: 11];
    back = 15'(q) * 15'(STEP_W);
    return back == 15'(v);
  endfunction

endpackage

// ===== design/dpw_pix_if.sv =====
// ----------------------------------------------------------------------------
// dpw_pix_if
// Pixel channel: valid/ready handshake with one pixel word.
// ----------------------------------------------------------------------------
interface dpw_pix_if;
  logic        valid;
  logic        ready;
  logic [10:0] pixel_row;
  logic [10:0] pixel_col;
  logic [15:0] depth_value;
  logic [7:0]  blue;
  logic [7:0]  green;
  logic [7:0]  red;

  modport source(output valid, pixel_row, pixel_col, depth_value, blue, green, red,
                 input ready);
  modport sink(input valid, pixel_row, pixel_col, depth_value, blue, green, red,
               output ready);
endinterface

// ===== design/dpw_pt_if.sv =====
// ----------------------------------------------------------------------------
// dpw_pt_if
// Point channel: valid/ready handshake with one world point word.
// ----------------------------------------------------------------------------
interface dpw_pt_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] world_x;
  logic signed [23:0] world_y;
  logic signed [23:0] world_z;
  logic [7:0]         point_blue;
  logic [7:0]         point_green;
  logic [7:0]         point_red;

  modport source(output valid, world_x, world_y, world_z, point_blue, point_green,
                 point_red, input ready);
  modport sink(input valid, world_x, world_y, world_z, point_blue, point_green,
               point_red, output ready);
endinterface

// ===== design/depth_pixel_to_world_point_core.sv =====
// Throughput: one pixel per cycle while the output is not stalled; the divide
// pipeline retires one pixel per cycle with one quotient bit resolved in each
// of its 32 stages.
// Dropped pixels leave a bubble and produce no point word.
// Reset (rst, synchronous) empties the pipe and loads the identity pose and
// default intrinsics.
// ----------------------------------------------------------------------------
// depth_pixel_to_world_point_core
// Back-projects sampled depth pixels through pinhole intrinsics and a rigid
// camera-to-world transform, emitting colored world points.
// ----------------------------------------------------------------------------
module depth_pixel_to_world_point_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  dpw_pix_if.sink     pix,
  dpw_pt_if.source    pt
);
  import dpw_pkg::*;

  cfg_t  cfg;
  logic  en;
  prod_t prod;
  cam_t  cam;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.focal_x  <= FOCAL_X_RST;
      cfg.focal_y  <= FOCAL_Y_RST;
      cfg.center_x <= CENTER_X_RST;
      cfg.center_y <= CENTER_Y_RST;
      cfg.pose_x   <= POSE_X_RST;
      cfg.pose_y   <= POSE_Y_RST;
      cfg.pose_z   <= POSE_Z_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FOCAL_X:  cfg.focal_x  <= cfg_data[15:0];
        REG_FOCAL_Y:  cfg.focal_y  <= cfg_data[15:0];
        REG_CENTER_X: cfg.center_x <= cfg_data[15:0];
        REG_CENTER_Y: cfg.center_y <= cfg_data[15:0];
        REG_POSE_X:   cfg.pose_x   <= cfg_data;
        REG_POSE_Y:   cfg.pose_y   <= cfg_data;
        REG_POSE_Z:   cfg.pose_z   <= cfg_data;
        default: ;
      endcase
    end
  end

  dpw_front u_front (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .cfg  (cfg),
    .pix  (pix),
    .prod (prod)
  );

  dpw_div u_div (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .prod (prod),
    .cam  (cam)
  );

  dpw_xform u_xform (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .cam (cam),
    .en  (en),
    .pt  (pt)
  );

`ifndef ASSERT_OFF
  // Writes to indexes past the last register leave the registers untouched.
  a_cfg_unknown: assert property (@(posedge clk) disable iff (rst)
    cfg_we && (cfg_index > REG_POSE_Z) |=> $stable(cfg))
    else $error("write to unknown register index changed configuration");
`endif

endmodule

// ===== design/dpw_front.sv =====
// ----------------------------------------------------------------------------
// dpw_front
// Input register, grid and depth filter, and offset times depth products.
// ----------------------------------------------------------------------------
module dpw_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  dpw_pkg::cfg_t cfg,
  dpw_pix_if.sink       pix,
  output dpw_pkg::prod_t prod
);
  import dpw_pkg::*;

  logic        v0;
  logic [10:0] row0;
  logic [10:0] col0;
  logic [15:0] dep0;
  logic [7:0]  b0;
  logic [7:0]  g0;
  logic [7:0]  r0;

  logic               keep;
  logic signed [16:0] off_x;
  logic signed [16:0] off_y;
  logic signed [16:0] neg_off_x;
  logic signed [16:0] neg_off_y;
  logic [15:0]        abs_x;
  logic [15:0]        abs_y;
  prod_t              prod_next;

  assign pix.ready = en;

  // Capture the pixel word.
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= pix.valid;
    end
    if (en) begin
      row0 <= pix.pixel_row;
      col0 <= pix.pixel_col;
      dep0 <= pix.depth_value;
      b0   <= pix.blue;
      g0   <= pix.green;
      r0   <= pix.red;
    end
  end

  // Filter, pixel offset from the principal point, and its product with depth.
  always_comb begin
    keep = on_grid(row0) && on_grid(col0) &&
           (dep0 >= DEPTH_MIN_KEEP) && (dep0 <= DEPTH_MAX_KEEP);
    off_x = $signed({2'b00, col0, 4'b0000}) - $signed({1'b0, cfg.center_x});
    off_y = $signed({2'b00, row0, 4'b0000}) - $signed({1'b0, cfg.center_y});
    neg_off_x = -off_x;
    neg_off_y = -off_y;
    abs_x = off_x[16] ? neg_off_x[15:0] : off_x[15:0];
    abs_y = off_y[16] ? neg_off_y[15:0] : off_y[15:0];
    prod_next.valid = v0 && keep;
    prod_next.mag_x = 32'(abs_x) * 32'(dep0);
    prod_next.mag_y = 32'(abs_y) * 32'(dep0);
    prod_next.neg_x = off_x[16];
    prod_next.neg_y = off_y[16];
    prod_next.den_x = (cfg.focal_x == 16'd0) ? 16'd1 : cfg.focal_x;
    prod_next.den_y = (cfg.focal_y == 16'd0) ? 16'd1 : cfg.focal_y;
    prod_next.depth = dep0;
    prod_next.blue  = b0;
    prod_next.green = g0;
    prod_next.red   = r0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod.valid <= 1'b0;
    end else if (en) begin
      prod <= prod_next;
    end
  end

endmodule

// ===== design/dpw_div.sv =====
// ----------------------------------------------------------------------------
// dpw_div
// Pipelined restoring divider for both camera axes, one quotient bit per
// stage, followed by a stage that restores the sign.
// ----------------------------------------------------------------------------
module dpw_div (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  dpw_pkg::prod_t prod,
  output dpw_pkg::cam_t  cam
);
  import dpw_pkg::*;

  dst_t st [QBITS];
  dst_t nxt [QBITS];
  cam_t cam_next;

  // One compare and subtract per stage on each axis.
  always_comb begin
    dst_t        cur;
    logic [16:0] trial_x;
    logic [16:0] trial_y;
    logic        bit_x;
    logic        bit_y;
    for (int k = 0; k < QBITS; k++) begin
      if (k == 0) begin
        cur.valid = prod.valid;
        cur.rem_x = '0;
        cur.rem_y = '0;
        cur.dvd_x = prod.mag_x;
        cur.dvd_y = prod.mag_y;
        cur.q_x   = '0;
        cur.q_y   = '0;
        cur.neg_x = prod.neg_x;
        cur.neg_y = prod.neg_y;
        cur.den_x = prod.den_x;
        cur.den_y = prod.den_y;
        cur.depth = prod.depth;
        cur.blue  = prod.blue;
        cur.green = prod.green;
        cur.red   = prod.red;
      end else begin
        cur = st[k-1];
      end
      trial_x = {cur.rem_x, cur.dvd_x[31]};
      trial_y = {cur.rem_y, cur.dvd_y[31]};
      bit_x = trial_x >= {1'b0, cur.den_x};
      bit_y = trial_y >= {1'b0, cur.den_y};
      nxt[k] = cur;
      nxt[k].rem_x = bit_x ? 16'(trial_x - {1'b0, cur.den_x}) : trial_x[15:0];
      nxt[k].rem_y = bit_y ? 16'(trial_y - {1'b0, cur.den_y}) : trial_y[15:0];
      nxt[k].dvd_x = {cur.dvd_x[30:0], 1'b0};
      nxt[k].dvd_y = {cur.dvd_y[30:0], 1'b0};
      nxt[k].q_x   = {cur.q_x[30:0], bit_x};
      nxt[k].q_y   = {cur.q_y[30:0], bit_y};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < QBITS; k++) begin
      if (rst) begin
        st[k].valid <= 1'b0;
      end else if (en) begin
        st[k] <= nxt[k];
      end
    end
  end

  // Quotients truncate toward zero: apply the sign to the magnitude.
  always_comb begin
    cam_next.valid = st[QBITS-1].valid;
    cam_next.x = st[QBITS-1].neg_x ? -$signed({1'b0, st[QBITS-1].q_x})
                                   : $signed({1'b0, st[QBITS-1].q_x});
    cam_next.y = st[QBITS-1].neg_y ? -$signed({1'b0, st[QBITS-1].q_y})
                                   : $signed({1'b0, st[QBITS-1].q_y});
    cam_next.depth = st[QBITS-1].depth;
    cam_next.blue  = st[QBITS-1].blue;
    cam_next.green = st[QBITS-1].green;
    cam_next.red   = st[QBITS-1].red;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cam.valid <= 1'b0;
    end else if (en) begin
      cam <= cam_next;
    end
  end

`ifndef ASSERT_OFF
  // A finished divide always leaves a remainder below the divisor.
  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    st[QBITS-1].valid |-> (st[QBITS-1].rem_x < st[QBITS-1].den_x) &&
                          (st[QBITS-1].rem_y < st[QBITS-1].den_y))
    else $error("divider remainder not below divisor");
`endif

endmodule

// ===== design/dpw_xform.sv =====
// ----------------------------------------------------------------------------
// dpw_xform
// Rigid transform into world frame: products, sum with rounding toward zero,
// saturation and the output register.
// ----------------------------------------------------------------------------
module dpw_xform (
  input  logic          clk,
  input  logic          rst,
  input  dpw_pkg::cfg_t cfg,
  input  dpw_pkg::cam_t cam,
  output logic          en,
  dpw_pt_if.source      pt
);
  import dpw_pkg::*;

  logic [63:0] pose [3];

  logic               v1;
  logic signed [48:0] p0 [3];
  logic signed [48:0] p1 [3];
  logic signed [32:0] p2 [3];
  logic signed [15:0] tr [3];
  logic [7:0]         b1;
  logic [7:0]         g1;
  logic [7:0]         r1;

  logic               v2;
  logic signed [36:0] q2 [3];
  logic [7:0]         b2;
  logic [7:0]         g2;
  logic [7:0]         r2;

  logic signed [36:0] q_next [3];
  logic signed [23:0] sat [3];
  logic signed [16:0] z_s;

  assign pose[0] = cfg.pose_x;
  assign pose[1] = cfg.pose_y;
  assign pose[2] = cfg.pose_z;
  assign z_s = $signed({1'b0, cam.depth});

  // The pipe moves unless a finished word is waiting on a full output.
  assign en = pt.ready || !pt.valid || !v2;

  // Rotation products for each world axis.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= cam.valid;
    end
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        p0[a] <= $signed(pose[a][15:0]) * cam.x;
        p1[a] <= $signed(pose[a][31:16]) * cam.y;
        p2[a] <= $signed(pose[a][47:32]) * z_s;
        tr[a] <= $signed(pose[a][63:48]);
      end
      b1 <= cam.blue;
      g1 <= cam.green;
      r1 <= cam.red;
    end
  end

  // Sum with translation, then divide by 2^14 truncating toward zero.
  always_comb begin
    logic signed [50:0] acc;
    logic signed [50:0] adj;
    for (int a = 0; a < 3; a++) begin
      acc = 51'(p0[a]) + 51'(p1[a]) + 51'(p2[a]) + (51'(tr[a]) <<< 18);
      adj = acc + (acc[50] ? 51'sd16383 : 51'sd0);
      q_next[a] = 37'(adj >>> 14);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        q2[a] <= q_next[a];
      end
      b2 <= b1;
      g2 <= g1;
      r2 <= r1;
    end
  end

  // Saturate to the output range.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (q2[a] > OUT_MAX) begin
        sat[a] = OUT_MAX[23:0];
      end else if (q2[a] < OUT_MIN) begin
        sat[a] = OUT_MIN[23:0];
      end else begin
        sat[a] = q2[a][23:0];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pt.valid <= 1'b0;
    end else if (pt.ready || !pt.valid) begin
      pt.valid <= v2;
    end
    if (pt.ready || !pt.valid) begin
      pt.world_x     <= sat[0];
      pt.world_y     <= sat[1];
      pt.world_z     <= sat[2];
      pt.point_blue  <= b2;
      pt.point_green <= g2;
      pt.point_red   <= r2;
    end
  end

`ifndef ASSERT_OFF
  // While the pipe is held, the last stage keeps its word.
  a_hold_last: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(v2) && $stable(q2[0]) && $stable(q2[1]) && $stable(q2[2]))
    else $error("last stage changed while held");
`endif

endmodule

// ===== test/depth_pixel_to_world_point_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// depth_pixel_to_world_point_core_tb
// Drives sampled and unsampled depth pixels under random idling on both
// channels, predicts each world point word in the testbench, and compares
// every point word field by field with the oldest expected word.
// ----------------------------------------------------------------------------
module depth_pixel_to_world_point_core_tb;
  import dpw_pkg::*;

  localparam int LATENCY = 38;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [10:0] row;
    logic [10:0] col;
    logic [15:0] depth;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
  } pixel_t;

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
    logic [7:0]         blue;
    logic [7:0]         green;
    logic [7:0]         red;
  } point_t;

  // Directed pixel with an optional expected point typed in.
  typedef struct {
    pixel_t pix;
    bit     typed;
    point_t pt;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;

  dpw_pix_if pix ();
  dpw_pt_if  pt ();

  depth_pixel_to_world_point_core uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .pix(pix.sink), .pt(pt.source)
  );

  // Shadow copies of the intrinsics and pose.
  logic [15:0] fx_q, fy_q, cx_q, cy_q;
  logic [63:0] pose_q [3];

  point_t point_queue [$];
  point_t typed_queue [$];
  bit     typed_flag  [$];
  int     fail_count = 0;
  int     cycle_count = 0;
  bit     calm = 0;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic signed [63:0] sx16(input logic [15:0] v);
    return 64'(signed'(v));
  endfunction

  // Back-projection with a quotient truncated toward zero.
  function automatic logic signed [63:0] cam_coord(input logic [10:0] p,
      input logic [15:0] ctr, input logic [15:0] foc, input logic [15:0] d);
    logic signed [63:0] off, f, dd;
    off = 64'(p) * 16 - 64'(ctr);
    f = (foc == 16'd0) ? 64'sd1 : 64'(foc);
    dd = 64'(d);
    return (off * dd) / f;
  endfunction

  function automatic logic signed [23:0] world_coord(input logic [63:0] r,
      input logic signed [63:0] x, input logic signed [63:0] y,
      input logic signed [63:0] z);
    logic signed [63:0] acc, q;
    acc = sx16(r[15:0]) * x + sx16(r[31:16]) * y + sx16(r[47:32]) * z
          + sx16(r[63:48]) * 64'sd262144;
    q = acc / 64'sd16384;
    if (q > 64'sd8388607) q = 64'sd8388607;
    if (q < -64'sd8388608) q = -64'sd8388608;
    return q[23:0];
  endfunction

  // Returns 1 and the world point when the pixel is kept.
  function automatic bit project_pixel(input pixel_t p, output point_t w);
    logic signed [63:0] x, y, z;
    w = '{default: 0};
    if (p.row % SAMPLE_STEP != 0 || p.col % SAMPLE_STEP != 0) return 0;
    if (p.depth < 16'd41 || p.depth > 16'd40960) return 0;
    x = cam_coord(p.col, cx_q, fx_q, p.depth);
    y = cam_coord(p.row, cy_q, fy_q, p.depth);
    z = 64'(p.depth);
    w.x = world_coord(pose_q[0], x, y, z);
    w.y = world_coord(pose_q[1], x, y, z);
    w.z = world_coord(pose_q[2], x, y, z);
    w.blue = p.blue;
    w.green = p.green;
    w.red = p.red;
    return 1;
  endfunction

  task automatic write_reg(input reg_idx_t idx, input logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_FOCAL_X: fx_q = val[15:0];
      REG_FOCAL_Y: fy_q = val[15:0];
      REG_CENTER_X: cx_q = val[15:0];
      REG_CENTER_Y: cy_q = val[15:0];
      REG_POSE_X: pose_q[0] = val;
      REG_POSE_Y: pose_q[1] = val;
      REG_POSE_Z: pose_q[2] = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Sends one pixel word and queues its expected point.
  task automatic send_pixel(input pixel_t p, input bit typed, input point_t tp);
    point_t w;
    while (!calm && $urandom_range(99) < 29) begin
      pix.valid <= 1'b0;
      @(posedge clk);
    end
    pix.valid <= 1'b1;
    pix.pixel_row <= p.row;
    pix.pixel_col <= p.col;
    pix.depth_value <= p.depth;
    pix.blue <= p.blue;
    pix.green <= p.green;
    pix.red <= p.red;
    do @(posedge clk); while (!pix.ready);
    if (project_pixel(p, w)) begin
      point_queue.insert(point_queue.size(), w);
      typed_flag.insert(typed_flag.size(), typed);
      typed_queue.insert(typed_queue.size(), tp);
    end
  endtask

  task automatic drain();
    pix.valid <= 1'b0;
    while (point_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic pixel_t rand_pixel(input bit grid);
    pixel_t p;
    p.row = 11'($urandom_range(2047));
    p.col = 11'($urandom_range(2047));
    if (grid) begin
      p.row = 11'(($urandom_range(682)) * 3);
      p.col = 11'(($urandom_range(682)) * 3);
      p.depth = $urandom_range(10) == 0 ? 16'($urandom) : 16'($urandom_range(40960, 41));
    end else begin
      p.depth = 16'($urandom);
    end
    p.blue = 8'($urandom);
    p.green = 8'($urandom);
    p.red = 8'($urandom);
    return p;
  endfunction

  // Output side: random stall and compare against the oldest expectation.
  always @(posedge clk) begin
    point_t w, t;
    bit tf;
    if (rst) begin
      pt.ready <= 1'b0;
    end else begin
      pt.ready <= calm || ($urandom_range(99) >= 29);
      if (pt.valid && pt.ready) begin
        if (point_queue.size() == 0) begin
          $error("point word with nothing expected");
          fail_count++;
        end else begin
          w = point_queue.pop_front();
          t = typed_queue.pop_front();
          tf = typed_flag.pop_front();
          if (tf && t != w) begin
            $error("predictor disagrees with typed row: expected %h got %h", t, w);
            fail_count++;
          end
          if (pt.world_x !== w.x) begin
            $error("world_x expected %0d got %0d", w.x, pt.world_x); fail_count++;
          end
          if (pt.world_y !== w.y) begin
            $error("world_y expected %0d got %0d", w.y, pt.world_y); fail_count++;
          end
          if (pt.world_z !== w.z) begin
            $error("world_z expected %0d got %0d", w.z, pt.world_z); fail_count++;
          end
          if (pt.point_blue !== w.blue) begin
            $error("point_blue expected %0d got %0d", w.blue, pt.point_blue);
            fail_count++;
          end
          if (pt.point_green !== w.green) begin
            $error("point_green expected %0d got %0d", w.green, pt.point_green);
            fail_count++;
          end
          if (pt.point_red !== w.red) begin
            $error("point_red expected %0d got %0d", w.red, pt.point_red);
            fail_count++;
          end
        end
      end
    end
  end

  initial begin
    dir_row_t dir_rows [$];
    point_t none;
    int n;
    none = '{default: 0};
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = 3'd0;
    cfg_data = 64'd0;
    pix.valid = 1'b0;
    pix.pixel_row = '0;
    pix.pixel_col = '0;
    pix.depth_value = '0;
    pix.blue = '0;
    pix.green = '0;
    pix.red = '0;
    fx_q = 16'd8000; fy_q = 16'd8000; cx_q = 16'd5120; cy_q = 16'd3840;
    pose_q[0] = 64'd16384; pose_q[1] = 64'd1073741824; pose_q[2] = 64'd70368744177664;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table under the reset focal lengths and identity pose, with the
    // principal point moved onto the sampling grid at row 240, col 321, where
    // x and y are zero.
    write_reg(REG_CENTER_X, 64'd5136);
    dir_rows.insert(dir_rows.size(), '{'{11'd240, 11'd321, 16'd4096, 8'd1, 8'd2, 8'd3}, 1,
                         '{24'sd0, 24'sd0, 24'sd4096, 8'd1, 8'd2, 8'd3}});
    dir_rows.insert(dir_rows.size(), '{'{11'd240, 11'd321, 16'd41, 8'hff, 8'h00, 8'hff}, 1,
                         '{24'sd0, 24'sd0, 24'sd41, 8'hff, 8'h00, 8'hff}});
    dir_rows.insert(dir_rows.size(), '{'{11'd240, 11'd321, 16'd40960, 8'h00, 8'hff, 8'h00},
                         1, '{24'sd0, 24'sd0, 24'sd40960, 8'h00, 8'hff, 8'h00}});
    dir_rows.insert(dir_rows.size(), '{'{11'd240, 11'd321, 16'd40, 8'd9, 8'd9, 8'd9}, 0, none});
    dir_rows.insert(dir_rows.size(),
                    '{'{11'd240, 11'd321, 16'd40961, 8'd9, 8'd9, 8'd9}, 0, none});
    dir_rows.insert(dir_rows.size(), '{'{11'd240, 11'd321, 16'd0, 8'd9, 8'd9, 8'd9}, 0, none});
    dir_rows.insert(dir_rows.size(),
                    '{'{11'd240, 11'd321, 16'hffff, 8'd9, 8'd9, 8'd9}, 0, none});
    dir_rows.insert(dir_rows.size(),
                    '{'{11'd241, 11'd321, 16'd4096, 8'd9, 8'd9, 8'd9}, 0, none});
    dir_rows.insert(dir_rows.size(),
                    '{'{11'd240, 11'd322, 16'd4096, 8'd9, 8'd9, 8'd9}, 0, none});
    dir_rows.insert(dir_rows.size(),
                    '{'{11'd2047, 11'd2047, 16'd4096, 8'd9, 8'd9, 8'd9}, 0, none});
    dir_rows.insert(dir_rows.size(), '{'{11'd0, 11'd0, 16'd40960, 8'd5, 8'd6, 8'd7}, 0, none});
    dir_rows.insert(dir_rows.size(),
                    '{'{11'd2046, 11'd2046, 16'd40960, 8'd5, 8'd6, 8'd7}, 0, none});
    dir_rows.insert(dir_rows.size(), '{'{11'd0, 11'd2046, 16'd41, 8'd5, 8'd6, 8'd7}, 0, none});
    dir_rows.insert(dir_rows.size(),
                    '{'{11'd2046, 11'd0, 16'd12345, 8'd5, 8'd6, 8'd7}, 0, none});
    foreach (dir_rows[i]) send_pixel(dir_rows[i].pix, dir_rows[i].typed, dir_rows[i].pt);
    drain();

    // Zero focal lengths act as one; extreme pose drives world x and y into saturation.
    write_reg(REG_FOCAL_X, 64'd0);
    write_reg(REG_FOCAL_Y, 64'd0);
    write_reg(REG_CENTER_X, 64'd0);
    write_reg(REG_CENTER_Y, 64'd65535);
    write_reg(REG_POSE_X, 64'h7fff_7fff_7fff_7fff);
    write_reg(REG_POSE_Y, 64'h8000_8000_8000_8000);
    write_reg(REG_POSE_Z, 64'hffff_ffff_ffff_ffff);
    send_pixel('{11'd0, 11'd2046, 16'd40960, 8'd1, 8'd1, 8'd1}, 0, none);
    send_pixel('{11'd2046, 11'd0, 16'd40960, 8'd2, 8'd2, 8'd2}, 0, none);
    send_pixel('{11'd3, 11'd3, 16'd41, 8'd3, 8'd3, 8'd3}, 0, none);
    drain();
    write_reg(REG_FOCAL_X, 64'hffff_ffff_ffff_ffff);
    write_reg(REG_FOCAL_Y, 64'hffff);
    write_reg(REG_CENTER_X, 64'hffff);
    write_reg(REG_CENTER_Y, 64'd0);
    for (int k = 0; k < 6; k++) send_pixel(rand_pixel(1), 0, none);
    drain();

    // Random phases, each with fresh registers.
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_FOCAL_X, ph == 1 ? 64'd1 : 64'($urandom_range(65535, 1)));
      write_reg(REG_FOCAL_Y, ph == 1 ? 64'd1 : 64'($urandom_range(65535, 1)));
      write_reg(REG_CENTER_X, 64'($urandom_range(65535)));
      write_reg(REG_CENTER_Y, 64'($urandom_range(65535)));
      write_reg(REG_POSE_X, {$urandom, $urandom});
      write_reg(REG_POSE_Y, {$urandom, $urandom});
      write_reg(REG_POSE_Z, {$urandom, $urandom});
      calm = (ph == 3);
      n = 0;
      while (n < 65) begin
        send_pixel(rand_pixel($urandom_range(99) < 75), 0, none);
        n++;
      end
      calm = 0;
      // Hold off until every point of this phase is back.
      drain();
    end

    drain();
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/dpw_pkg.sv
design/dpw_pix_if.sv
design/dpw_pt_if.sv
design/dpw_front.sv
design/dpw_div.sv
design/dpw_xform.sv
design/depth_pixel_to_world_point_core.sv
test/depth_pixel_to_world_point_core_tb.sv
